// File: hdl/crcfe_pkg.sv
// shared types, constants and the crc-16/x.25 byte update for the frame encoder
// no dependencies
package crcfe_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [7:0]  SYNC_BYTE = 8'hFF;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        PH_ITEM,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    // reflected crc update, one byte, lsb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/crc16_frame_encoder_core.sv
// frame encoder core: header, payload pass-through and crc-16/x.25 trailer
// depends on crcfe_pkg (scoped references only)
//
// Accepts start and data beats on the s_ side and sends the encoded frame one byte per beat on
// the m_ side. A start beat yields FF FF, version, sequence and LENGTH_BYTES big-endian length
// bytes (plus the two crc bytes when the length is zero). A data beat yields its payload byte,
// followed by the two crc bytes when it is the last payload byte; a data beat outside a frame
// is dropped without output. The next input beat is taken in the same cycle that the current
// one sends its final byte, so payload streams at one byte per cycle while m_tready holds high.
// The crc covers version through payload, is sent high byte first and closes with m_tuser set;
// m_tlast marks the final byte caused by each input beat. The user must write the version
// register through the cfg port only while the block is idle; the block does not enforce it.
module crc16_frame_encoder_core #(
    parameter int LENGTH_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // version_byte
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // seq_number[7:0], payload_length[23:8], data_byte[31:24]
    input  logic [0:0]  s_tuser,       // command
    // output beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // out_byte
    output logic        m_tlast,       // run_last
    output logic [0:0]  m_tuser        // frame_end
);

    localparam int PosW   = $clog2(LENGTH_BYTES + 4);
    localparam int LenExW = 8 * LENGTH_BYTES;
    localparam logic [PosW-1:0] HdrLast = PosW'(LENGTH_BYTES + 3);
    localparam logic [PosW-1:0] PosVer  = PosW'(2);
    localparam logic [PosW-1:0] PosSeq  = PosW'(3);

    // held input item
    logic                  item_vld_reg;
    crcfe_pkg::cmd_t       item_cmd_reg;
    logic [7:0]            item_seq_reg;
    logic [15:0]           item_len_reg;
    logic [7:0]            item_dat_reg;
    logic [PosW-1:0]       pos_reg, pos_next;
    crcfe_pkg::phase_t     phase_reg, phase_next;

    // frame state
    logic [7:0]            version_reg;
    logic [15:0]           crc_reg, crc_next;
    logic [15:0]           left_reg, left_next;
    logic                  in_frame_reg, in_frame_next;

    // output register
    logic                  m_valid_reg;
    logic [7:0]            m_data_reg;
    logic                  m_last_reg;
    logic                  m_user_reg;

    logic                  out_free;
    logic                  drop;
    logic                  step;
    logic                  emit;
    logic                  item_done;
    logic                  go_crc;
    logic [7:0]            emit_byte;
    logic                  emit_end;
    logic                  s_fire;
    logic [LenExW-1:0]     len_ext;
    logic [LenExW-1:0]     len_shift;
    logic [15:0]           left_dec;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign drop      = item_vld_reg && (item_cmd_reg == crcfe_pkg::CMD_DATA) && !in_frame_reg
                       && (phase_reg == crcfe_pkg::PH_ITEM);
    assign step      = item_vld_reg && (drop || out_free);
    assign s_tready  = !item_vld_reg || (step && item_done);
    assign s_fire    = s_tvalid && s_tready;

    assign len_ext   = LenExW'(item_len_reg);
    assign len_shift = len_ext >> {(HdrLast - pos_reg), 3'b000};
    assign left_dec  = left_reg - 16'd1;

    // byte selection and frame state update for the current position
    always_comb begin
        emit          = 1'b0;
        item_done     = 1'b0;
        go_crc        = 1'b0;
        emit_byte     = crcfe_pkg::SYNC_BYTE;
        emit_end      = 1'b0;
        crc_next      = crc_reg;
        left_next     = left_reg;
        in_frame_next = in_frame_reg;
        case (phase_reg)
            crcfe_pkg::PH_ITEM: begin
                if (drop) begin
                    item_done = 1'b1;
                end else if (item_cmd_reg == crcfe_pkg::CMD_START) begin
                    emit = 1'b1;
                    if (pos_reg == PosVer) begin
                        emit_byte = version_reg;
                        crc_next  = crcfe_pkg::crc_feed(crcfe_pkg::CRC_INIT, version_reg);
                    end else if (pos_reg == PosSeq) begin
                        emit_byte = item_seq_reg;
                        crc_next  = crcfe_pkg::crc_feed(crc_reg, item_seq_reg);
                    end else if (pos_reg > PosSeq) begin
                        emit_byte = len_shift[7:0];
                        crc_next  = crcfe_pkg::crc_feed(crc_reg, len_shift[7:0]);
                    end
                    if (pos_reg == HdrLast) begin
                        left_next     = item_len_reg;
                        in_frame_next = 1'b1;
                        if (item_len_reg == 16'd0) begin
                            go_crc = 1'b1;
                        end else begin
                            item_done = 1'b1;
                        end
                    end
                end else begin
                    emit      = 1'b1;
                    emit_byte = item_dat_reg;
                    crc_next  = crcfe_pkg::crc_feed(crc_reg, item_dat_reg);
                    left_next = left_dec;
                    if (left_dec == 16'd0) begin
                        go_crc = 1'b1;
                    end else begin
                        item_done = 1'b1;
                    end
                end
            end
            crcfe_pkg::PH_CRC_HI: begin
                emit      = 1'b1;
                emit_byte = ~crc_reg[15:8];
            end
            crcfe_pkg::PH_CRC_LO: begin
                emit          = 1'b1;
                emit_byte     = ~crc_reg[7:0];
                emit_end      = 1'b1;
                item_done     = 1'b1;
                in_frame_next = 1'b0;
                left_next     = 16'd0;
            end
            default: begin
                item_done = 1'b1;
            end
        endcase
    end

    // phase and position sequencing
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        if (s_fire) begin
            pos_next = '0;
        end else if (step && phase_reg == crcfe_pkg::PH_ITEM && !item_done && !go_crc) begin
            pos_next = pos_reg + PosW'(1);
        end
        if (step) begin
            case (phase_reg)
                crcfe_pkg::PH_ITEM: begin
                    if (go_crc) begin
                        phase_next = crcfe_pkg::PH_CRC_HI;
                    end
                end
                crcfe_pkg::PH_CRC_HI: begin
                    phase_next = crcfe_pkg::PH_CRC_LO;
                end
                default: begin
                    phase_next = crcfe_pkg::PH_ITEM;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
            phase_reg    <= crcfe_pkg::PH_ITEM;
            pos_reg      <= '0;
            version_reg  <= 8'h00;
            crc_reg      <= crcfe_pkg::CRC_INIT;
            left_reg     <= 16'd0;
            in_frame_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                version_reg <= cfg_data;
            end
            if (s_fire) begin
                item_vld_reg <= 1'b1;
            end else if (step && item_done) begin
                item_vld_reg <= 1'b0;
            end
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            if (step) begin
                crc_reg      <= crc_next;
                left_reg     <= left_next;
                in_frame_reg <= in_frame_next;
            end
            if (step && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_cmd_reg <= crcfe_pkg::cmd_t'(s_tuser[0]);
            item_seq_reg <= s_tdata[7:0];
            item_len_reg <= s_tdata[23:8];
            item_dat_reg <= s_tdata[31:24];
        end
        if (step && emit) begin
            m_data_reg <= emit_byte;
            m_last_reg <= item_done;
            m_user_reg <= emit_end;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_user_reg;

endmodule
